// ===== hdl/lrp_pkg.sv =====
// ----------------------------------------------------------------------------
// lrp_pkg: shared types for the LR shift-reduce parse engine
// Opcodes, action and event kinds, beat payloads, queue entries and FSM states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrp_pkg;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int QAW     = 2;

    typedef enum logic [1:0] {
        OP_ACT_WR  = 2'd0,
        OP_GOTO_WR = 2'd1,
        OP_TOKEN   = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        AK_EMPTY  = 2'd0,
        AK_SHIFT  = 2'd1,
        AK_REDUCE = 2'd2,
        AK_ACCEPT = 2'd3
    } act_kind_t;

    typedef enum logic [1:0] {
        EV_SHIFT  = 2'd0,
        EV_REDUCE = 2'd1,
        EV_ACCEPT = 2'd2,
        EV_ERROR  = 2'd3
    } ev_kind_t;

    typedef struct packed {
        op_t         opcode;
        logic [7:0]  table_state;
        logic [5:0]  symbol_code;
        act_kind_t   action_kind;
        logic [7:0]  action_target;
        logic [3:0]  rhs_length;
        logic [7:0]  goto_target;
    } in_item_t;

    typedef struct packed {
        ev_kind_t    event_kind;
        logic [5:0]  event_symbol;
        logic [7:0]  from_state;
        logic [7:0]  below_state;
        logic [7:0]  pushed_state;
        logic        last;
    } out_item_t;

    // Classified command held in the queue
    typedef struct packed {
        op_t         op;
        logic        wr_ok;
        logic [7:0]  row;
        logic [5:0]  sym;
        act_kind_t   kind;
        logic [7:0]  target;
        logic [3:0]  len;
        logic [7:0]  gt;
    } cmd_t;

    // Back-end status seen by the front end
    typedef struct packed {
        logic pop;
        logic clear_done;
    } back_stat_t;

    typedef struct packed {
        act_kind_t   kind;
        logic [7:0]  target;
        logic [3:0]  len;
    } act_entry_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  state;
    } goto_entry_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_DEC,
        BK_RED,
        BK_GOTO
    } bk_state_t;

endpackage

// ===== hdl/lrp_front.sv =====
// ----------------------------------------------------------------------------
// lrp_front: input acceptance, classification and command queue
// Checks table-write state and symbol codes against the table bounds and queues each beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrp_front
    import lrp_pkg::*;
#(
    parameter int NUM_STATES       = 256,
    parameter int NUM_TERMINALS    = 64,
    parameter int NUM_NONTERMINALS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       q_valid,
    output cmd_t       q_cmd,
    input  back_stat_t stat
);

    cmd_t           q_mem_reg [Q_DEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic           accept;
    cmd_t           cmd;

    assign in_ready = (count_reg != (QAW+1)'(Q_DEPTH)) && stat.clear_done;
    assign accept   = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = q_mem_reg[rd_ptr_reg];

    // Classify the incoming beat
    always_comb
    begin
        cmd.op     = in_data.opcode;
        cmd.row    = in_data.table_state;
        cmd.sym    = in_data.symbol_code;
        cmd.kind   = in_data.action_kind;
        cmd.target = in_data.action_target;
        cmd.len    = in_data.rhs_length;
        cmd.gt     = in_data.goto_target;
        unique case (in_data.opcode) inside
            OP_ACT_WR:
            begin
                cmd.wr_ok = (32'(in_data.table_state) < NUM_STATES)
                         && (32'(in_data.symbol_code) < NUM_TERMINALS);
            end
            OP_GOTO_WR:
            begin
                cmd.wr_ok = (32'(in_data.table_state) < NUM_STATES)
                         && (32'(in_data.symbol_code) < NUM_NONTERMINALS);
            end
            OP_TOKEN, OP_RESTART:
            begin
                cmd.wr_ok = 1'b0;
            end
            default:
            begin
                cmd.wr_ok = 1'b0;
            end
        endcase
    end

    // Store the beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (stat.pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (accept && !stat.pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!accept && stat.pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/lrp_back.sv =====
// ----------------------------------------------------------------------------
// lrp_back: parse execution engine
// Holds the action, goto and state-stack memories, runs table writes,
// restarts and the shift/reduce sequence of each token, and drives events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrp_back
    import lrp_pkg::*;
#(
    parameter int NUM_STATES       = 256,
    parameter int NUM_TERMINALS    = 64,
    parameter int NUM_NONTERMINALS = 64,
    parameter int STACK_DEPTH      = 256,
    parameter int MAX_RHS          = 15,
    parameter int MAX_REDUCTIONS   = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  cmd_t       q_cmd,
    output back_stat_t stat,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data
);

    localparam int ACT_DEPTH  = NUM_STATES * NUM_TERMINALS;
    localparam int GOTO_DEPTH = NUM_STATES * NUM_NONTERMINALS;
    localparam int CLR_DEPTH  = (ACT_DEPTH > GOTO_DEPTH) ? ACT_DEPTH : GOTO_DEPTH;
    localparam int ACT_AW     = $clog2(ACT_DEPTH);
    localparam int GOTO_AW    = $clog2(GOTO_DEPTH);
    localparam int CLR_W      = $clog2(CLR_DEPTH);
    localparam int SAW        = $clog2(STACK_DEPTH);
    localparam int SPW        = $clog2(STACK_DEPTH + 1);
    localparam int RW         = $clog2(MAX_REDUCTIONS + 1);

    // Memories
    act_entry_t  act_mem   [ACT_DEPTH];
    goto_entry_t goto_mem  [GOTO_DEPTH];
    logic [7:0]  stack_mem [STACK_DEPTH];

    logic               act_we;
    logic [ACT_AW-1:0]  act_waddr;
    act_entry_t         act_wdata;
    logic               act_re;
    logic [ACT_AW-1:0]  act_raddr;
    act_entry_t         act_rd_reg;

    logic               goto_we;
    logic [GOTO_AW-1:0] goto_waddr;
    goto_entry_t        goto_wdata;
    logic               goto_re;
    logic [GOTO_AW-1:0] goto_raddr;
    goto_entry_t        goto_rd_reg;

    logic               stk_we;
    logic [SAW-1:0]     stk_waddr;
    logic [7:0]         stk_wdata;
    logic               stk_re;
    logic [SAW-1:0]     stk_raddr;
    logic [7:0]         stk_rd_reg;

    // Control state
    bk_state_t          state_reg, state_next;
    logic [CLR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [SPW-1:0]     sp_reg, sp_next;
    logic [SPW-1:0]     base_reg, base_next;
    logic [7:0]         top_reg, top_next;
    logic               halted_reg, halted_next;
    logic [RW-1:0]      reds_reg, reds_next;
    logic [5:0]         tok_reg, tok_next;
    logic               act_ok_reg, act_ok_next;
    logic               goto_ok_reg, goto_ok_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;

    logic               can_emit;
    logic [7:0]         lk_state;
    logic [5:0]         lk_sym;
    act_entry_t         act_cur;
    goto_entry_t        goto_cur;

    assign can_emit        = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign act_cur         = act_ok_reg ? act_rd_reg : '0;
    assign goto_cur        = goto_ok_reg ? goto_rd_reg : '0;
    assign act_raddr       = ACT_AW'(32'(lk_state) * NUM_TERMINALS + 32'(lk_sym));
    assign goto_raddr      = GOTO_AW'(32'(stk_rd_reg) * NUM_NONTERMINALS
                                      + 32'(act_cur.target));

    // Action table port
    always_ff @(posedge clk)
    begin
        if (act_we)
        begin
            act_mem[act_waddr] <= act_wdata;
        end
        if (act_re)
        begin
            act_rd_reg <= act_mem[act_raddr];
        end
    end

    // Goto table port
    always_ff @(posedge clk)
    begin
        if (goto_we)
        begin
            goto_mem[goto_waddr] <= goto_wdata;
        end
        if (goto_re)
        begin
            goto_rd_reg <= goto_mem[goto_raddr];
        end
    end

    // State stack port
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stack_mem_rd: stk_rd_reg <= stack_mem[stk_raddr];
        end
    end

    // Hold control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_cnt_reg   <= '0;
            sp_reg        <= SPW'(1);
            top_reg       <= '0;
            halted_reg    <= 1'b0;
            reds_reg      <= '0;
            act_ok_reg    <= 1'b0;
            goto_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            sp_reg        <= sp_next;
            top_reg       <= top_next;
            halted_reg    <= halted_next;
            reds_reg      <= reds_next;
            act_ok_reg    <= act_ok_next;
            goto_ok_reg   <= goto_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        tok_reg      <= tok_next;
        out_data_reg <= out_data_next;
    end

    // Sequence commands and tokens
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        sp_next         = sp_reg;
        base_next       = base_reg;
        top_next        = top_reg;
        halted_next     = halted_reg;
        reds_next       = reds_reg;
        tok_next        = tok_reg;
        act_ok_next     = act_ok_reg;
        goto_ok_next    = goto_ok_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        stat.pop        = 1'b0;
        stat.clear_done = (state_reg != BK_CLEAR);
        act_we          = 1'b0;
        act_waddr       = ACT_AW'(32'(q_cmd.row) * NUM_TERMINALS + 32'(q_cmd.sym));
        act_wdata       = '{kind: q_cmd.kind, target: q_cmd.target, len: q_cmd.len};
        act_re          = 1'b0;
        lk_state        = top_reg;
        lk_sym          = q_cmd.sym;
        goto_we         = 1'b0;
        goto_waddr      = GOTO_AW'(32'(q_cmd.row) * NUM_NONTERMINALS + 32'(q_cmd.sym));
        goto_wdata      = '{valid: 1'b1, state: q_cmd.gt};
        goto_re         = 1'b0;
        stk_we          = 1'b0;
        stk_waddr       = '0;
        stk_wdata       = '0;
        stk_re          = 1'b0;
        stk_raddr       = SAW'(32'(sp_reg) - 32'(act_cur.len) - 1);

        unique case (state_reg)
            BK_CLEAR:
            begin
                // Sweep both tables to empty, seed the stack bottom
                act_we     = (32'(clr_cnt_reg) < ACT_DEPTH);
                act_waddr  = clr_cnt_reg[ACT_AW-1:0];
                act_wdata  = '0;
                goto_we    = (32'(clr_cnt_reg) < GOTO_DEPTH);
                goto_waddr = clr_cnt_reg[GOTO_AW-1:0];
                goto_wdata = '0;
                stk_we     = 1'b1;
                if (32'(clr_cnt_reg) == CLR_DEPTH - 1)
                begin
                    state_next = BK_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            BK_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_cmd.op)
                        OP_ACT_WR:
                        begin
                            stat.pop = 1'b1;
                            act_we   = q_cmd.wr_ok;
                        end
                        OP_GOTO_WR:
                        begin
                            stat.pop = 1'b1;
                            goto_we  = q_cmd.wr_ok;
                        end
                        OP_RESTART:
                        begin
                            stat.pop    = 1'b1;
                            sp_next     = SPW'(1);
                            top_next    = '0;
                            halted_next = 1'b0;
                            stk_we      = 1'b1;
                        end
                        default:
                        begin
                            // Token: error at once when halted, else look up
                            if (halted_reg)
                            begin
                                if (can_emit)
                                begin
                                    stat.pop       = 1'b1;
                                    out_valid_next = 1'b1;
                                    out_data_next  = '{EV_ERROR, q_cmd.sym, top_reg,
                                                       8'd0, 8'd0, 1'b1};
                                end
                            end
                            else
                            begin
                                stat.pop    = 1'b1;
                                tok_next    = q_cmd.sym;
                                reds_next   = '0;
                                act_re      = 1'b1;
                                act_ok_next = (32'(top_reg) < NUM_STATES)
                                           && (32'(q_cmd.sym) < NUM_TERMINALS);
                                state_next  = BK_DEC;
                            end
                        end
                    endcase
                end
            end

            BK_DEC:
            begin
                unique case (act_cur.kind)
                    AK_SHIFT:
                    begin
                        if (can_emit)
                        begin
                            out_valid_next = 1'b1;
                            state_next     = BK_IDLE;
                            if (32'(sp_reg) >= STACK_DEPTH)
                            begin
                                halted_next   = 1'b1;
                                out_data_next = '{EV_ERROR, tok_reg, top_reg,
                                                  8'd0, 8'd0, 1'b1};
                            end
                            else
                            begin
                                stk_we        = 1'b1;
                                stk_waddr     = sp_reg[SAW-1:0];
                                stk_wdata     = act_cur.target;
                                sp_next       = sp_reg + 1'b1;
                                top_next      = act_cur.target;
                                out_data_next = '{EV_SHIFT, tok_reg, top_reg,
                                                  8'd0, act_cur.target, 1'b1};
                            end
                        end
                    end
                    AK_ACCEPT:
                    begin
                        if (can_emit)
                        begin
                            halted_next    = 1'b1;
                            out_valid_next = 1'b1;
                            out_data_next  = '{EV_ACCEPT, tok_reg, top_reg,
                                               8'd0, 8'd0, 1'b1};
                            state_next     = BK_IDLE;
                        end
                    end
                    AK_REDUCE:
                    begin
                        if ((32'(reds_reg) >= MAX_REDUCTIONS)
                            || (32'(act_cur.len) > MAX_RHS)
                            || (32'(act_cur.len) >= 32'(sp_reg)))
                        begin
                            if (can_emit)
                            begin
                                halted_next    = 1'b1;
                                out_valid_next = 1'b1;
                                out_data_next  = '{EV_ERROR, tok_reg, top_reg,
                                                   8'd0, 8'd0, 1'b1};
                                state_next     = BK_IDLE;
                            end
                        end
                        else
                        begin
                            // Pop: read the exposed state
                            base_next  = SPW'(32'(sp_reg) - 32'(act_cur.len));
                            stk_re     = 1'b1;
                            state_next = BK_RED;
                        end
                    end
                    default:
                    begin
                        if (can_emit)
                        begin
                            halted_next    = 1'b1;
                            out_valid_next = 1'b1;
                            out_data_next  = '{EV_ERROR, tok_reg, top_reg,
                                               8'd0, 8'd0, 1'b1};
                            state_next     = BK_IDLE;
                        end
                    end
                endcase
            end

            BK_RED:
            begin
                // Look up goto from the exposed state
                goto_re      = 1'b1;
                goto_ok_next = (32'(stk_rd_reg) < NUM_STATES)
                            && (32'(act_cur.target) < NUM_NONTERMINALS);
                state_next   = BK_GOTO;
            end

            BK_GOTO:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    if (!goto_cur.valid || (32'(base_reg) >= STACK_DEPTH))
                    begin
                        halted_next   = 1'b1;
                        out_data_next = '{EV_ERROR, tok_reg, top_reg,
                                          8'd0, 8'd0, 1'b1};
                        state_next    = BK_IDLE;
                    end
                    else
                    begin
                        // Push goto state, then look up the token again
                        stk_we        = 1'b1;
                        stk_waddr     = base_reg[SAW-1:0];
                        stk_wdata     = goto_cur.state;
                        sp_next       = base_reg + 1'b1;
                        top_next      = goto_cur.state;
                        reds_next     = reds_reg + 1'b1;
                        out_data_next = '{EV_REDUCE, act_cur.target[5:0], top_reg,
                                          stk_rd_reg, goto_cur.state, 1'b0};
                        lk_state      = goto_cur.state;
                        lk_sym        = tok_reg;
                        act_re        = 1'b1;
                        act_ok_next   = (32'(goto_cur.state) < NUM_STATES)
                                     && (32'(tok_reg) < NUM_TERMINALS);
                        state_next    = BK_DEC;
                    end
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/lr_shift_reduce_parser.sv =====
// A token is popped from the queue as its action is read, then decoded; a shift, accept or
// error event is then registered to out_valid. Each reduction before it adds a pop read, a
// goto read and an action re-read on the registered stack, goto and action ports. One table
// write or restart per cycle while the back end is idle; a token waits until the last is done.
// Reset: a sweep over max(NUM_STATES*NUM_TERMINALS, NUM_STATES*NUM_NONTERMINALS)
// entries (16384 at the defaults) empties both tables; in_ready stays low until done.
// ----------------------------------------------------------------------------
// lr_shift_reduce_parser: table-driven LR parse engine
// Front end queues classified beats; back end loads tables and parses tokens.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lr_shift_reduce_parser
    import lrp_pkg::*;
#(
    parameter int NUM_STATES       = 256,
    parameter int NUM_TERMINALS    = 64,
    parameter int NUM_NONTERMINALS = 64,
    parameter int STACK_DEPTH      = 256,
    parameter int MAX_RHS          = 15,
    parameter int MAX_REDUCTIONS   = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic       q_valid;
    cmd_t       q_cmd;
    back_stat_t stat;

    lrp_front #(
        .NUM_STATES       (NUM_STATES),
        .NUM_TERMINALS    (NUM_TERMINALS),
        .NUM_NONTERMINALS (NUM_NONTERMINALS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .stat     (stat)
    );

    lrp_back #(
        .NUM_STATES       (NUM_STATES),
        .NUM_TERMINALS    (NUM_TERMINALS),
        .NUM_NONTERMINALS (NUM_NONTERMINALS),
        .STACK_DEPTH      (STACK_DEPTH),
        .MAX_RHS          (MAX_RHS),
        .MAX_REDUCTIONS   (MAX_REDUCTIONS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== hdl/lrp_checker.sv =====
// ----------------------------------------------------------------------------
// lrp_sva: port-level checks for the LR parse engine
// Watches the event stream for framing and field rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrp_sva
    import lrp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // Hold a stalled event beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("event beat changed while stalled");

    // Reductions never close a token
    a_reduce_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.event_kind == EV_REDUCE) |-> !out_data.last)
        else $error("reduce event marked last");

    // Every other event closes the token with no exposed state
    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.event_kind != EV_REDUCE)
        |-> out_data.last && (out_data.below_state == 8'd0))
        else $error("final event framing wrong");

    // Accept and error push nothing
    a_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((out_data.event_kind == EV_ACCEPT)
                      || (out_data.event_kind == EV_ERROR))
        |-> (out_data.pushed_state == 8'd0))
        else $error("accept or error carries a pushed state");

endmodule

bind lr_shift_reduce_parser lrp_sva u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== verif/lrp_checker.sv =====
// ----------------------------------------------------------------------------
// lrp_checker: parse event predictor and scoreboard
// Watches both channels of the parse engine, predicts the events each accepted
// beat causes from its own copy of the tables and stack, and compares them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrp_checker
    import lrp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        fail_count,
    output int        pending_events
);

    localparam int NST  = 256;
    localparam int NSYM = 64;
    localparam int SDEP = 256;
    localparam int MRHS = 15;
    localparam int MRED = 32;

    act_entry_t  act_mem [NST*NSYM];
    goto_entry_t goto_mem[NST*NSYM];
    logic [7:0]  stk[SDEP];
    int          depth;
    logic        stopped;
    out_item_t   event_q[$];

    assign pending_events = event_q.size();

    task automatic report(input string what, input out_item_t got, input out_item_t want);
        begin
            fail_count++;
            $display("MISMATCH %s: got %p want %p at %0t", what, got, want, $realtime);
        end
    endtask

    function automatic out_item_t mk_event(ev_kind_t k, logic [5:0] s, logic [7:0] f,
                                           logic [7:0] b, logic [7:0] n, logic l);
        out_item_t e;
        e.event_kind = k; e.event_symbol = s; e.from_state = f;
        e.below_state = b; e.pushed_state = n; e.last = l;
        return e;
    endfunction

    // Append one expected event
    task automatic queue_event(input out_item_t e);
        begin
            event_q = {event_q, e};
        end
    endtask

    // Run one token through the tables and queue the events it yields
    task automatic parse_token(input logic [5:0] term);
        act_entry_t  a;
        goto_entry_t g;
        logic [7:0]  top;
        int          reds;
        int          base;
        begin
            reds = 0;
            forever
            begin
                top = stk[depth-1];
                if (stopped)
                begin
                    queue_event(mk_event(EV_ERROR, term, top, 0, 0, 1));
                    return;
                end
                a = act_mem[{top, term}];
                if (a.kind == AK_SHIFT)
                begin
                    if (depth >= SDEP)
                    begin
                        stopped = 1;
                        queue_event(mk_event(EV_ERROR, term, top, 0, 0, 1));
                    end
                    else
                    begin
                        stk[depth] = a.target;
                        depth++;
                        queue_event(mk_event(EV_SHIFT, term, top, 0, a.target, 1));
                    end
                    return;
                end
                if (a.kind == AK_REDUCE && reds < MRED && a.len <= MRHS && a.len < depth)
                begin
                    base = depth - a.len;
                    if (a.target < NSYM)
                        g = goto_mem[{stk[base-1], a.target[5:0]}];
                    else
                        g = '0;
                    if (g.valid && base < SDEP)
                    begin
                        queue_event(mk_event(EV_REDUCE, a.target[5:0], top,
                                             stk[base-1], g.state, 0));
                        stk[base] = g.state;
                        depth = base + 1;
                        reds++;
                        continue;
                    end
                end
                stopped = 1;
                queue_event(mk_event(a.kind == AK_ACCEPT ? EV_ACCEPT : EV_ERROR,
                                     term, top, 0, 0, 1));
                return;
            end
        end
    endtask

    initial
    begin
        fail_count = 0;
        foreach (act_mem[i]) act_mem[i] = '0;
        foreach (goto_mem[i]) goto_mem[i] = '0;
        stk[0] = 0;
        depth = 1;
        stopped = 0;
    end

    // Predict on accepted input beats
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            case (in_data.opcode)
                OP_ACT_WR:
                    act_mem[{in_data.table_state, in_data.symbol_code}] =
                        '{in_data.action_kind, in_data.action_target, in_data.rhs_length};
                OP_GOTO_WR:
                    goto_mem[{in_data.table_state, in_data.symbol_code}] =
                        '{1'b1, in_data.goto_target};
                OP_TOKEN:
                    parse_token(in_data.symbol_code);
                default:
                begin
                    stk[0] = 0;
                    depth = 1;
                    stopped = 0;
                end
            endcase
        end
    end

    // Compare accepted output beats
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (event_q.size() == 0)
                report("unexpected event", out_data, '0);
            else
            begin
                want = event_q.pop_front();
                if (out_data.event_kind !== want.event_kind)
                    report("event_kind", out_data, want);
                else if (out_data.event_symbol !== want.event_symbol)
                    report("event_symbol", out_data, want);
                else if (out_data.from_state !== want.from_state)
                    report("from_state", out_data, want);
                else if (out_data.below_state !== want.below_state)
                    report("below_state", out_data, want);
                else if (out_data.pushed_state !== want.pushed_state)
                    report("pushed_state", out_data, want);
                else if (out_data.last !== want.last)
                    report("last", out_data, want);
            end
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the LR parse engine
// Loads small grammars, feeds token streams with random gaps and stalls,
// and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import lrp_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    int        fail_count;
    int        pending_events;
    logic      stall_free;

    lr_shift_reduce_parser u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    lrp_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending_events(pending_events)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Time limit
    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    // Receiver stalls, with quiet stretches
    initial
    begin
        int wait_cycles;
        out_ready = 0;
        stall_free = 0;
        forever
        begin
            @(negedge clk);
            wait_cycles = stall_free ? 0 : $urandom_range(0, 5);
            repeat (wait_cycles)
            begin
                out_ready = 0;
                @(negedge clk);
            end
            out_ready = 1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Drive one beat with a random gap before it
    task automatic send_beat(input in_item_t beat, input logic no_gap);
        int gap;
        begin
            gap = no_gap ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                in_valid <= 0;
                repeat (gap) @(negedge clk);
            end
            in_data  <= beat;
            in_valid <= 1;
            do @(posedge clk); while (!in_ready);
            @(negedge clk);
        end
    endtask

    // Fill every field of a beat with random bits
    function automatic in_item_t rand_beat();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return in_item_t'(raw[$bits(in_item_t)-1:0]);
    endfunction

    function automatic in_item_t act_wr(logic [7:0] st, logic [5:0] t, act_kind_t k,
                                        logic [7:0] tg, logic [3:0] len);
        in_item_t b;
        b = rand_beat();
        b.opcode = OP_ACT_WR; b.table_state = st; b.symbol_code = t;
        b.action_kind = k; b.action_target = tg; b.rhs_length = len;
        return b;
    endfunction

    function automatic in_item_t goto_wr(logic [7:0] st, logic [5:0] nt, logic [7:0] gt);
        in_item_t b;
        b = rand_beat();
        b.opcode = OP_GOTO_WR; b.table_state = st; b.symbol_code = nt; b.goto_target = gt;
        return b;
    endfunction

    function automatic in_item_t token(logic [5:0] t);
        in_item_t b;
        b = rand_beat();
        b.opcode = OP_TOKEN; b.symbol_code = t;
        return b;
    endfunction

    function automatic in_item_t restart_beat();
        in_item_t b;
        b = rand_beat();
        b.opcode = OP_RESTART;
        return b;
    endfunction

    initial
    begin
        logic no_gap;
        int   n;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        repeat (11) @(negedge clk);
        rst_n = 1;

        // Directed: token on empty tables, halted token, restart
        no_gap = 0;
        send_beat(token(6'd63), no_gap);
        send_beat(token(6'd0), no_gap);
        send_beat(restart_beat(), no_gap);
        // State 0: shift '1' to 255; state 255 reduces '2' by length 1 to nt 63, goto 7; state 7 accepts '2'
        send_beat(act_wr(8'd0, 6'd1, AK_SHIFT, 8'd255, 4'd0), no_gap);
        send_beat(act_wr(8'd255, 6'd2, AK_REDUCE, 8'd63, 4'd1), no_gap);
        send_beat(goto_wr(8'd0, 6'd63, 8'd7), no_gap);
        send_beat(act_wr(8'd7, 6'd2, AK_ACCEPT, 8'd0, 4'd0), no_gap);
        send_beat(token(6'd1), no_gap);
        send_beat(token(6'd2), no_gap);
        send_beat(token(6'd2), no_gap);
        send_beat(restart_beat(), no_gap);
        // Epsilon reduce looping in state 0 hits the reduction limit
        send_beat(act_wr(8'd0, 6'd5, AK_REDUCE, 8'd10, 4'd0), no_gap);
        send_beat(goto_wr(8'd0, 6'd10, 8'd0), no_gap);
        send_beat(token(6'd5), no_gap);
        send_beat(restart_beat(), no_gap);
        // Over-long reduce and missing goto
        send_beat(act_wr(8'd0, 6'd6, AK_REDUCE, 8'd11, 4'd15), no_gap);
        send_beat(token(6'd6), no_gap);
        send_beat(restart_beat(), no_gap);
        send_beat(act_wr(8'd0, 6'd8, AK_REDUCE, 8'd200, 4'd0), no_gap);
        send_beat(token(6'd8), no_gap);
        send_beat(restart_beat(), no_gap);
        // On '9', epsilon reductions walk states 0..15, then shift back to 0:
        // each token pushes 16 states until the stack overflows
        for (int i = 0; i < 15; i++)
        begin
            send_beat(act_wr(8'(i), 6'd9, AK_REDUCE, 8'd20, 4'd0), no_gap);
            send_beat(goto_wr(8'(i), 6'd20, 8'(i + 1)), no_gap);
        end
        send_beat(act_wr(8'd15, 6'd9, AK_SHIFT, 8'd0, 4'd0), no_gap);
        stall_free = 1;
        for (int i = 0; i < 17; i++)
            send_beat(token(6'd9), 1'b1);
        stall_free = 0;
        send_beat(restart_beat(), no_gap);

        // Random: small grammar over states 0..7, symbols 0..7, mostly tokens
        n = 0;
        while (n < 160)
        begin
            int r;
            in_item_t b;
            no_gap = ($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 99);
            if (r < 20)
                b = act_wr(8'($urandom_range(0, 7)), 6'($urandom_range(0, 7)),
                           act_kind_t'($urandom_range(1, 3)), 8'($urandom_range(0, 7)),
                           4'($urandom_range(0, 3)));
            else if (r < 32)
                b = goto_wr(8'($urandom_range(0, 7)), 6'($urandom_range(0, 7)),
                            8'($urandom_range(0, 7)));
            else if (r < 37)
                b = rand_beat();
            else if (r < 42)
                b = restart_beat();
            else
                b = token(6'($urandom_range(0, 7)));
            if (r >= 32 && r < 37 && b.opcode != OP_TOKEN && b.opcode != OP_RESTART)
                b = token(b.symbol_code);
            send_beat(b, no_gap);
            if (b.opcode == OP_TOKEN && $urandom_range(0, 3) == 0)
                send_beat(restart_beat(), no_gap);
            n++;
        end
        in_valid <= 0;

        while (pending_events != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/lrp_pkg.sv
hdl/lrp_front.sv
hdl/lrp_back.sv
hdl/lr_shift_reduce_parser.sv
hdl/lrp_checker.sv
verif/lrp_checker.sv
verif/tb_top.sv
